// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared result kinds, character codes, UTF-8 limits and the result bundle
// that passes from the decoder to the result buffer.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Most results one text byte can cause: three UTF-8 bytes plus an error
    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int SlotW      = $clog2(MaxResults);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Characters with a meaning inside a string
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ESC_B  = 8'h62;
    localparam logic [7:0] CH_ESC_F  = 8'h66;
    localparam logic [7:0] CH_ESC_N  = 8'h6e;
    localparam logic [7:0] CH_ESC_R  = 8'h72;
    localparam logic [7:0] CH_ESC_T  = 8'h74;
    localparam logic [7:0] CH_ESC_U  = 8'h75;

    // Control bytes produced by the short escapes
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0c;
    localparam logic [7:0] CTL_LF = 8'h0a;
    localparam logic [7:0] CTL_CR = 8'h0d;
    localparam logic [7:0] CTL_HT = 8'h09;

    // UTF-8 length limits
    localparam logic [15:0] CP_ONE_MAX = 16'h007f;
    localparam logic [15:0] CP_TWO_MAX = 16'h07ff;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    // Results of one text byte, slot 0 first
    typedef struct packed {
        t_result [MaxResults-1:0] entry;
        logic [CountW-1:0]        count;
    } t_bundle;

endpackage

// File: hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the parse state and turns one text byte into its bundle of results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_text_byte,
    input  logic            i_string_start,
    input  logic            i_text_end,
    output jsu_pkg::t_bundle o_bundle
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_HEX
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_seen, n_hex_seen;
    logic [15:0] r_acc, n_acc;

    // Map an ASCII hex digit to {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Decode one byte against the current state
    always_comb begin
        logic [4:0]        hv;
        logic [15:0]       cp;
        logic [CountW-1:0] cnt;
        t_bundle           b;

        hv         = hex_value(i_text_byte);
        cp         = {r_acc[11:0], hv[3:0]};
        cnt        = '0;
        b          = '0;
        n_mode     = r_mode;
        n_hex_seen = r_hex_seen;
        n_acc      = r_acc;

        if (i_string_start) begin
            n_hex_seen = 2'd0;
            n_acc      = 16'd0;
            if (i_text_byte == CH_QUOTE) begin
                n_mode = MODE_STRING;
            end else begin
                n_mode = MODE_IDLE;
                b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_ERROR};
                cnt = cnt + CountW'(1);
            end
        end else begin
            case (r_mode)
                MODE_STRING: begin
                    if (i_text_byte == CH_QUOTE) begin
                        n_mode = MODE_IDLE;
                        b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_DONE};
                        cnt = cnt + CountW'(1);
                    end else if (i_text_byte == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        b.entry[cnt[SlotW-1:0]] = '{data: i_text_byte, kind: KIND_BYTE};
                        cnt = cnt + CountW'(1);
                    end
                end
                MODE_ESCAPE: begin
                    n_mode = MODE_STRING;
                    b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_BYTE};
                    case (i_text_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH:
                            b.entry[cnt[SlotW-1:0]].data = i_text_byte;
                        CH_ESC_B: b.entry[cnt[SlotW-1:0]].data = CTL_BS;
                        CH_ESC_F: b.entry[cnt[SlotW-1:0]].data = CTL_FF;
                        CH_ESC_N: b.entry[cnt[SlotW-1:0]].data = CTL_LF;
                        CH_ESC_R: b.entry[cnt[SlotW-1:0]].data = CTL_CR;
                        CH_ESC_T: b.entry[cnt[SlotW-1:0]].data = CTL_HT;
                        default: ;
                    endcase
                    if (i_text_byte == CH_ESC_U) begin
                        // start of four hex digits, nothing emitted yet
                        n_mode     = MODE_HEX;
                        n_hex_seen = 2'd0;
                        n_acc      = 16'd0;
                        b.entry[cnt[SlotW-1:0]] = '0;
                    end else if (i_text_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH,
                                                     CH_ESC_B, CH_ESC_F, CH_ESC_N,
                                                     CH_ESC_R, CH_ESC_T}) begin
                        cnt = cnt + CountW'(1);
                    end else begin
                        n_mode = MODE_IDLE;
                        b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_ERROR};
                        cnt = cnt + CountW'(1);
                    end
                end
                MODE_HEX: begin
                    if (!hv[4]) begin
                        n_mode     = MODE_IDLE;
                        n_hex_seen = 2'd0;
                        b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_ERROR};
                        cnt = cnt + CountW'(1);
                    end else begin
                        n_acc = cp;
                        if (r_hex_seen == 2'd3) begin
                            n_hex_seen = 2'd0;
                            n_mode     = MODE_STRING;
                            // encode the code point as UTF-8
                            if (cp <= CP_ONE_MAX) begin
                                b.entry[cnt[SlotW-1:0]] = '{data: cp[7:0], kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                            end else if (cp <= CP_TWO_MAX) begin
                                b.entry[cnt[SlotW-1:0]] =
                                    '{data: {3'b110, cp[10:6]}, kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                                b.entry[cnt[SlotW-1:0]] =
                                    '{data: {2'b10, cp[5:0]}, kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                            end else begin
                                b.entry[cnt[SlotW-1:0]] =
                                    '{data: {4'b1110, cp[15:12]}, kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                                b.entry[cnt[SlotW-1:0]] =
                                    '{data: {2'b10, cp[11:6]}, kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                                b.entry[cnt[SlotW-1:0]] =
                                    '{data: {2'b10, cp[5:0]}, kind: KIND_BYTE};
                                cnt = cnt + CountW'(1);
                            end
                        end else begin
                            n_hex_seen = r_hex_seen + 2'd1;
                        end
                    end
                end
                default: ; // idle: ignore the byte
            endcase
        end

        // Text ran out with a string still open
        if (i_text_end && n_mode != MODE_IDLE) begin
            n_mode     = MODE_IDLE;
            n_hex_seen = 2'd0;
            b.entry[cnt[SlotW-1:0]] = '{data: 8'd0, kind: KIND_ERROR};
            cnt = cnt + CountW'(1);
        end

        b.count  = cnt;
        o_bundle = b;
    end

    // Advance the parse state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_hex_seen <= 2'd0;
            r_acc      <= 16'd0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_hex_seen <= n_hex_seen;
            r_acc      <= n_acc;
        end
    end

endmodule

// File: hdl/jsu_emit.sv
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Registers one bundle of results and shifts them out one beat at a time.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_decoded_byte,
    output logic [1:0]       o_result_kind,
    output logic             o_last_of_run
);
    import jsu_pkg::*;

    t_result [MaxResults-1:0] r_entry;
    logic [CountW-1:0]        r_count;
    logic                     pop;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    // Take a new bundle once the held one is gone or leaves this cycle
    assign o_free      = (r_count == '0) || (r_count == CountW'(1) && i_out_ready);

    assign o_decoded_byte = r_entry[0].data;
    assign o_result_kind  = r_entry[0].kind;
    assign o_last_of_run  = (r_count == CountW'(1));

    // Count of results still held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= i_bundle.count;
        end else if (pop) begin
            r_count <= r_count - CountW'(1);
        end
    end

    // Load a bundle, or shift the next result to the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_bundle.entry;
        end else if (pop) begin
            for (int k = 0; k < MaxResults - 1; k++) begin
                r_entry[k] <= r_entry[k+1];
            end
        end
    end

endmodule

// File: hdl/json_string_unescape_utf8_core.sv
// Output: the first result appears on the output in the cycle after its text byte is accepted.
// Throughput: one text byte per cycle while each byte makes at most one result and the output
// does not stall; a byte that makes n results (n up to 4) holds off the next byte until the
// single result buffer, draining one beat per cycle when not stalled, is down to its last result.
// Reset: synchronous, active low; clears parse state and empties the result buffer.
// ----------------------------------------------------------------------------
// JSON string unescape core
// Decodes a JSON string value byte by byte, expanding escapes and \u code
// points into UTF-8, and reports completion or errors as result beats.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_string_start,
    input  logic       i_text_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_decoded_byte,
    output logic [1:0] o_result_kind,
    output logic       o_last_of_run
);
    import jsu_pkg::*;

    t_bundle bundle;
    logic    accept;
    logic    free;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    // Parse state and per-byte decode
    jsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_text_byte    (i_text_byte),
        .i_string_start (i_string_start),
        .i_text_end     (i_text_end),
        .o_bundle       (bundle)
    );

    // Result register and output sequencing
    jsu_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_bundle       (bundle),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_decoded_byte (o_decoded_byte),
        .o_result_kind  (o_result_kind),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// File: tb/sv/json_unescape_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON unescape result checker
// Watches both channels of the unescape core, decodes every accepted text
// beat on its own, and compares each result beat with the oldest result
// still due. Hands the number of results due and of mismatches to the top.
// ----------------------------------------------------------------------------
module json_unescape_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_string_start,
    input  logic       i_text_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_decoded_byte,
    input  logic [1:0] i_result_kind,
    input  logic       i_last_of_run,
    output int         o_pending,
    output int         o_error_count
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_TEXT,
        SCAN_ESCAPE,
        SCAN_HEX
    } t_scan;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_expect;

    t_scan       scan = SCAN_IDLE;
    logic [1:0]  hex_count = '0;
    logic [15:0] code_point = '0;
    t_expect     results_due[$];
    t_expect     want;
    int          mismatch_count = 0;

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Append one expected result to the tail of the due list
    task automatic queue_result(input t_kind kind, input logic [7:0] data);
        t_expect r;
        r.data = data;
        r.kind = kind;
        r.last = 1'b0;
        results_due.insert(results_due.size(), r);
    endtask

    // Bit 4 set marks a byte that is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Decode one text beat and queue the results it causes
    task automatic decode_text_byte(input logic [7:0] b, input logic s, input logic e);
        int         first_new;
        logic [4:0] digit;
        first_new = results_due.size();
        if (s) begin
            hex_count  = '0;
            code_point = '0;
            if (b == CH_QUOTE) begin
                scan = SCAN_TEXT;
            end else begin
                scan = SCAN_IDLE;
                queue_result(KIND_ERROR, 8'h00);
            end
        end else begin
            case (scan)
                SCAN_TEXT: begin
                    if (b == CH_QUOTE) begin
                        scan = SCAN_IDLE;
                        queue_result(KIND_DONE, 8'h00);
                    end else if (b == CH_BSLASH) begin
                        scan = SCAN_ESCAPE;
                    end else begin
                        queue_result(KIND_BYTE, b);
                    end
                end
                SCAN_ESCAPE: begin
                    scan = SCAN_TEXT;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: queue_result(KIND_BYTE, b);
                        CH_ESC_B: queue_result(KIND_BYTE, CTL_BS);
                        CH_ESC_F: queue_result(KIND_BYTE, CTL_FF);
                        CH_ESC_N: queue_result(KIND_BYTE, CTL_LF);
                        CH_ESC_R: queue_result(KIND_BYTE, CTL_CR);
                        CH_ESC_T: queue_result(KIND_BYTE, CTL_HT);
                        CH_ESC_U: begin
                            scan       = SCAN_HEX;
                            hex_count  = '0;
                            code_point = '0;
                        end
                        default: begin
                            scan = SCAN_IDLE;
                            queue_result(KIND_ERROR, 8'h00);
                        end
                    endcase
                end
                SCAN_HEX: begin
                    digit = hex_nibble(b);
                    if (digit[4]) begin
                        scan      = SCAN_IDLE;
                        hex_count = '0;
                        queue_result(KIND_ERROR, 8'h00);
                    end else begin
                        code_point = {code_point[11:0], digit[3:0]};
                        if (hex_count == 2'd3) begin
                            hex_count = '0;
                            scan      = SCAN_TEXT;
                            // Emit the code point as UTF-8, no surrogate joining
                            if (code_point <= CP_ONE_MAX) begin
                                queue_result(KIND_BYTE, code_point[7:0]);
                            end else if (code_point <= CP_TWO_MAX) begin
                                queue_result(KIND_BYTE, {3'b110, code_point[10:6]});
                                queue_result(KIND_BYTE, {2'b10, code_point[5:0]});
                            end else begin
                                queue_result(KIND_BYTE, {4'b1110, code_point[15:12]});
                                queue_result(KIND_BYTE, {2'b10, code_point[11:6]});
                                queue_result(KIND_BYTE, {2'b10, code_point[5:0]});
                            end
                        end else begin
                            hex_count = hex_count + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Text ran out with a string still open
        if (e && scan != SCAN_IDLE) begin
            scan      = SCAN_IDLE;
            hex_count = '0;
            queue_result(KIND_ERROR, 8'h00);
        end

        // Mark the final result of this beat
        if (results_due.size() > first_new)
            results_due[results_due.size() - 1].last = 1'b1;
    endtask

    // Compare result beats first: a beat on this edge comes from an earlier text beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan       = SCAN_IDLE;
            hex_count  = '0;
            code_point = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing due: kind %0d byte %02h",
                                            i_result_kind, i_decoded_byte));
                end else begin
                    want = results_due.pop_front();
                    if (i_result_kind !== want.kind)
                        flag_mismatch($sformatf("result_kind %0d, expected %s",
                                                i_result_kind, want.kind.name()));
                    if (i_decoded_byte !== want.data)
                        flag_mismatch($sformatf("decoded_byte %02h, expected %02h",
                                                i_decoded_byte, want.data));
                    if (i_last_of_run !== want.last)
                        flag_mismatch($sformatf("last_of_run %b, expected %b",
                                                i_last_of_run, want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                decode_text_byte(i_text_byte, i_string_start, i_text_end);
        end
        o_pending     <= results_due.size();
        o_error_count <= mismatch_count;
    end

endmodule

// File: tb/sv/json_string_unescape_utf8_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescape core testbench
// Feeds directed and random JSON text (well-formed strings with random
// content, broken strings and stray bytes) into the core, with random idle
// bursts on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_test;
    import jsu_pkg::*;

    localparam int HalfPeriod  = 4;
    localparam int ResetCycles = 5;
    localparam int RandomItems = 410;
    localparam int QuietItems  = 60;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 200000;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte    = 8'h00;
    logic       string_start = 1'b0;
    logic       text_end     = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] decoded_byte;
    logic [1:0] result_kind;
    logic       last_of_run;

    int pending;
    int errors;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int live_items  = 0;
    int cycles      = 0;
    bit paused_once = 1'b0;

    always #(HalfPeriod) clk = ~clk;

    json_string_unescape_utf8_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_text_byte    (text_byte),
        .i_string_start (string_start),
        .i_text_end     (text_end),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_decoded_byte (decoded_byte),
        .o_result_kind  (result_kind),
        .o_last_of_run  (last_of_run)
    );

    json_unescape_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_text_byte    (text_byte),
        .i_string_start (string_start),
        .i_text_end     (text_end),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_decoded_byte (decoded_byte),
        .i_result_kind  (result_kind),
        .i_last_of_run  (last_of_run),
        .o_pending      (pending),
        .o_error_count  (errors)
    );

    // Drop ready in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Send one text beat, maybe after an idle burst; hold it until accepted
    task automatic send_text(input logic [7:0] b, input logic s, input logic e,
                             input bit counted = 1'b1);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= b;
        string_start <= s;
        text_end     <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (counted)
            live_items++;
    endtask

    task automatic send_chars(input string txt);
        for (int k = 0; k < txt.len(); k++)
            send_text(txt[k], 1'b0, 1'b0);
    endtask

    // Stop sending until every result due has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_escape(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_ESC_B ||
               c == CH_ESC_F || c == CH_ESC_N || c == CH_ESC_R || c == CH_ESC_T ||
               c == CH_ESC_U;
    endfunction

    function automatic logic [7:0] short_escape(input int idx);
        case (idx)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_ESC_B;
            4:       return CH_ESC_F;
            5:       return CH_ESC_N;
            6:       return CH_ESC_R;
            default: return CH_ESC_T;
        endcase
    endfunction

    // Hex digit character for a nibble, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return {4'h0, n} + 8'h30;
        // 'A' - 10 and 'a' - 10
        return {4'h0, n} + ($urandom_range(0, 1) ? 8'h37 : 8'h57);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [15:0] random_code_point();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, CP_ONE_MAX));
            1:       return 16'($urandom_range(CP_ONE_MAX + 1, CP_TWO_MAX));
            default: return 16'($urandom_range(CP_TWO_MAX + 1, 16'hffff));
        endcase
    endfunction

    // Send \u and four digits; the end flag rides on the last digit
    task automatic send_code_point(input logic [15:0] cp, input logic e);
        send_text(CH_BSLASH, 1'b0, 1'b0);
        send_text(CH_ESC_U, 1'b0, 1'b0);
        send_text(hex_char(cp[15:12]), 1'b0, 1'b0);
        send_text(hex_char(cp[11:8]), 1'b0, 1'b0);
        send_text(hex_char(cp[7:4]), 1'b0, 1'b0);
        send_text(hex_char(cp[3:0]), 1'b0, e);
    endtask

    task automatic send_random_piece();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_text(plain_byte(), 1'b0, 1'b0);
            5, 6: begin
                send_text(CH_BSLASH, 1'b0, 1'b0);
                send_text(short_escape($urandom_range(0, 7)), 1'b0, 1'b0);
            end
            default: send_code_point(random_code_point(), 1'b0);
        endcase
    endtask

    // Break an open string in one of several ways
    task automatic send_broken_tail();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: begin
                send_text(CH_BSLASH, 1'b0, 1'b0);
                do b = 8'($urandom_range(0, 255)); while (is_escape(b));
                send_text(b, 1'b0, 1'b0);
            end
            1: begin
                send_text(CH_BSLASH, 1'b0, 1'b0);
                send_text(CH_ESC_U, 1'b0, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_text(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b0);
                do b = 8'($urandom_range(0, 255)); while (is_hex(b));
                send_text(b, 1'b0, 1'b0);
            end
            2: send_text(plain_byte(), 1'b0, 1'b1);
            3: send_text(CH_BSLASH, 1'b0, 1'b1);
            4: begin
                send_text(CH_BSLASH, 1'b0, 1'b0);
                send_text(CH_ESC_U, 1'b0, 1'b0);
                send_text(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b1);
            end
            5: send_code_point(random_code_point(), 1'b1);
            6: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                send_text(b, 1'b1, 1'b0);
            end
            default: ;  // leave it open: the next start flag abandons it
        endcase
    endtask

    task automatic send_random_string();
        send_text(CH_QUOTE, 1'b1, 1'b0);
        repeat ($urandom_range(0, 10)) send_random_piece();
        if ($urandom_range(0, 4) == 0)
            send_broken_tail();
        else
            send_text(CH_QUOTE, 1'b0, $urandom_range(0, 3) == 0);
    endtask

    // Stray text between strings
    task automatic send_noise();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 3))
                   send_text(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                             1'b0);
            1: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                send_text(b, 1'b1, 1'($urandom_range(0, 1)));
            end
            2: send_text(CH_QUOTE, 1'b1, 1'b1);
            default: ;
        endcase
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    initial begin
        repeat (ResetCycles) @(posedge clk);
        rst_n     <= 1'b1;
        gap_pct   = 25;
        stall_pct = 25;

        // Directed: idle bytes, bad start, extremes, escapes, UTF-8 lengths
        send_text("x", 1'b0, 1'b0);
        send_text("a", 1'b0, 1'b1);
        send_text("a", 1'b1, 1'b0);
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_text(8'h00, 1'b0, 1'b0);
        send_text(8'hff, 1'b0, 1'b0);
        send_chars("\\u07Ff");
        send_text(CH_QUOTE, 1'b0, 1'b0);
        send_text("z", 1'b0, 1'b0);
        // Three UTF-8 bytes plus the text-end error on one beat
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_chars("\\uFfF");
        send_text("F", 1'b0, 1'b1);
        // Restart mid-string, then text ends inside the string
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_text("a", 1'b0, 1'b0);
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_text("c", 1'b0, 1'b1);
        // Bad hex digit and bad escape
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_chars("\\ug");
        send_text(CH_QUOTE, 1'b1, 1'b0);
        send_chars("\\q");
        hold_until_drained();

        // Random strings with changing idle pressure, quiet at the tail
        live_items = 0;
        while (live_items < RandomItems) begin
            if (live_items >= RandomItems - QuietItems) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            if (!paused_once && live_items >= RandomItems / 2) begin
                hold_until_drained();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                send_noise();
            send_random_string();
        end
        in_valid <= 1'b0;

        // Drain, let the pipeline settle, then give the verdict
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial begin
        while (cycles < CycleLimit) begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_emit.sv
hdl/json_string_unescape_utf8_core.sv
tb/sv/json_unescape_result_checker.sv
tb/sv/json_string_unescape_utf8_core_test.sv
